FILE: src/sm83ljc_pkg.sv
// Shared types and constants for the SM83 load/jump/compare unit.
// No dependencies.
package sm83ljc_pkg;

  // register file indices
  localparam logic [2:0] RegA = 3'd0;
  localparam logic [2:0] RegB = 3'd1;
  localparam logic [2:0] RegC = 3'd2;
  localparam logic [2:0] RegD = 3'd3;
  localparam logic [2:0] RegE = 3'd4;
  localparam logic [2:0] RegH = 3'd5;
  localparam logic [2:0] RegL = 3'd6;

  localparam logic [2:0] CodeMem = 3'd6;
  localparam logic [15:0] HighPage = 16'hFF00;

  // flag bit positions
  localparam int FlagZ = 3;
  localparam int FlagN = 2;
  localparam int FlagH = 1;
  localparam int FlagC = 0;

  // opcodes with arms of their own
  localparam logic [7:0] OpNop    = 8'h00;
  localparam logic [7:0] OpLdBc   = 8'h01;
  localparam logic [7:0] OpStBc   = 8'h02;
  localparam logic [7:0] OpStSp   = 8'h08;
  localparam logic [7:0] OpLdABc  = 8'h0A;
  localparam logic [7:0] OpLdDe   = 8'h11;
  localparam logic [7:0] OpStDe   = 8'h12;
  localparam logic [7:0] OpJr     = 8'h18;
  localparam logic [7:0] OpLdADe  = 8'h1A;
  localparam logic [7:0] OpJrNz   = 8'h20;
  localparam logic [7:0] OpLdHl   = 8'h21;
  localparam logic [7:0] OpStHli  = 8'h22;
  localparam logic [7:0] OpJrZ    = 8'h28;
  localparam logic [7:0] OpLdAHli = 8'h2A;
  localparam logic [7:0] OpJrNc   = 8'h30;
  localparam logic [7:0] OpLdSp   = 8'h31;
  localparam logic [7:0] OpStHld  = 8'h32;
  localparam logic [7:0] OpJrC    = 8'h38;
  localparam logic [7:0] OpLdAHld = 8'h3A;
  localparam logic [7:0] OpHalt   = 8'h76;
  localparam logic [7:0] OpJp     = 8'hC3;
  localparam logic [7:0] OpLdhSt  = 8'hE0;
  localparam logic [7:0] OpStHc   = 8'hE2;
  localparam logic [7:0] OpStA16  = 8'hEA;
  localparam logic [7:0] OpLdhLd  = 8'hF0;
  localparam logic [7:0] OpLdHc   = 8'hF2;
  localparam logic [7:0] OpLdHlSp = 8'hF8;
  localparam logic [7:0] OpLdSpHl = 8'hF9;
  localparam logic [7:0] OpLdA16  = 8'hFA;
  localparam logic [7:0] OpCpImm  = 8'hFE;

  typedef struct packed {
    logic [7:0] func;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
  } in_word_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  acc_value;
    logic [15:0] hl_value;
    logic [3:0]  flag_bits;
    logic [4:0]  cycle_count;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
    logic        unimplemented;
  } out_word_t;

  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [7:0]  data;
  } mem_wr_t;

  // operand code to register index; the (HL) code never reaches here
  function automatic logic [2:0] code_reg(input logic [2:0] code);
    logic [2:0] r;
    unique case (code)
      3'd0: r = RegB;
      3'd1: r = RegC;
      3'd2: r = RegD;
      3'd3: r = RegE;
      3'd4: r = RegH;
      3'd5: r = RegL;
      default: r = RegA;
    endcase
    return r;
  endfunction

endpackage

FILE: src/sm83ljc_mem.sv
// Data memory: one write port, one registered read port, sweep clear after reset.
// Depends on sm83ljc_pkg.
module sm83ljc_mem import sm83ljc_pkg::*; #(
  parameter int Depth = 65536,
  parameter int Aw    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [Aw-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  mem_wr_t       wr_i,
  output logic          busy_o
);

  logic [7:0]    mem [Depth];
  logic [Aw-1:0] clr_q, clr_d;
  logic          busy_q, busy_d;
  logic [7:0]    rd_data_q;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == Aw'(Depth - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= 8'h00;
    end else if (wr_i.en) begin
      mem[wr_i.addr[Aw-1:0]] <= wr_i.data;
    end
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

FILE: src/sm83ljc_core.sv
// Instruction execute: register file, flags, SP, PC, read issue and write-back.
// Depends on sm83ljc_pkg; drives the data memory ports.
module sm83ljc_core import sm83ljc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mem_busy_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o,
  output logic        rd_en_o,
  output logic [15:0] rd_addr_o,
  input  logic [7:0]  rd_data_i,
  output mem_wr_t     wr_o
);

  logic [7:0]  rf_q [7];
  logic [7:0]  rf_d [7];
  logic [3:0]  flag_q, flag_d;
  logic [15:0] sp_q, sp_d;
  logic [15:0] pc_q, pc_d;
  in_word_t    a_q;
  logic        a_vld_q;
  logic        hi_pend_q;
  logic [15:0] hi_addr_q;
  logic [7:0]  hi_data_q;
  out_word_t   out_q, res;
  logic        out_vld_q;

  logic        in_acc, exec;
  logic [15:0] hl, bc, de, a16, off, addr_x, target, hl_adj;
  logic [7:0]  op, lo, src_v;
  logic [2:0]  src, dst;
  logic [1:0]  len;
  logic [4:0]  cyc;
  logic        bad, jump, take;
  logic [4:0]  h_sum;
  logic [8:0]  c_sum;
  mem_wr_t     wr_x;

  function automatic logic [3:0] cmp_flags(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] f;
    f        = 4'b0000;
    f[FlagN] = 1'b1;
    f[FlagZ] = (a == b);
    f[FlagH] = (a[3:0] < b[3:0]);
    f[FlagC] = (a < b);
    return f;
  endfunction

  // one item in execute at a time; second byte of LD (a16),SP holds the write port
  assign in_stall_o = mem_busy_i | a_vld_q | hi_pend_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign exec       = a_vld_q & (~out_vld_q | ~out_stall_i);

  assign hl = {rf_q[RegH], rf_q[RegL]};
  assign bc = {rf_q[RegB], rf_q[RegC]};
  assign de = {rf_q[RegD], rf_q[RegE]};

  // read address from the incoming word against current registers
  always_comb begin
    rd_addr_o = hl;
    case (in_data_i.func)
      OpLdABc: rd_addr_o = bc;
      OpLdADe: rd_addr_o = de;
      OpLdhLd: rd_addr_o = HighPage + {8'h00, in_data_i.imm_low};
      OpLdHc:  rd_addr_o = HighPage + {8'h00, rf_q[RegC]};
      OpLdA16: rd_addr_o = {in_data_i.imm_high, in_data_i.imm_low};
      default: rd_addr_o = hl;
    endcase
  end
  assign rd_en_o = in_acc;

  assign op     = a_q.func;
  assign lo     = a_q.imm_low;
  assign a16    = {a_q.imm_high, a_q.imm_low};
  assign src    = op[2:0];
  assign dst    = op[5:3];
  assign off    = {{8{lo[7]}}, lo};
  assign src_v  = (src == CodeMem) ? rd_data_i : rf_q[code_reg(src)];
  assign h_sum  = {1'b0, sp_q[3:0]} + {1'b0, lo[3:0]};
  assign c_sum  = {1'b0, sp_q[7:0]} + {1'b0, lo};
  assign target = pc_q + 16'd2 + off;
  assign hl_adj = (op == OpStHli || op == OpLdAHli) ? hl + 16'd1 : hl - 16'd1;

  always_comb begin
    for (int i = 0; i < 7; i++) rf_d[i] = rf_q[i];
    flag_d = flag_q;
    sp_d   = sp_q;
    len    = 2'd1;
    cyc    = 5'd0;
    bad    = 1'b0;
    jump   = 1'b0;
    take   = 1'b0;
    addr_x = '0;
    wr_x   = '0;
    case (op) inside
      [8'h40:8'h75], [8'h77:8'h7F]: begin
        if (dst == CodeMem) begin
          wr_x = '{en: 1'b1, addr: hl, data: src_v};
        end else begin
          rf_d[code_reg(dst)] = src_v;
        end
        cyc = (dst == CodeMem || src == CodeMem) ? 5'd8 : 5'd4;
      end
      [8'hB8:8'hBF]: begin
        flag_d = cmp_flags(rf_q[RegA], src_v);
        cyc    = (src == CodeMem) ? 5'd8 : 5'd4;
      end
      8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E: begin
        len = 2'd2;
        if (dst == CodeMem) begin
          wr_x = '{en: 1'b1, addr: hl, data: lo};
          cyc  = 5'd12;
        end else begin
          rf_d[code_reg(dst)] = lo;
          cyc = 5'd8;
        end
      end
      OpNop: cyc = 5'd4;
      OpLdBc: begin
        rf_d[RegB] = a_q.imm_high; rf_d[RegC] = lo; len = 2'd3; cyc = 5'd12;
      end
      OpLdDe: begin
        rf_d[RegD] = a_q.imm_high; rf_d[RegE] = lo; len = 2'd3; cyc = 5'd12;
      end
      OpLdHl: begin
        rf_d[RegH] = a_q.imm_high; rf_d[RegL] = lo; len = 2'd3; cyc = 5'd12;
      end
      OpLdSp: begin
        sp_d = a16; len = 2'd3; cyc = 5'd12;
      end
      OpStBc: begin
        wr_x = '{en: 1'b1, addr: bc, data: rf_q[RegA]}; cyc = 5'd8;
      end
      OpStDe: begin
        wr_x = '{en: 1'b1, addr: de, data: rf_q[RegA]}; cyc = 5'd8;
      end
      OpLdABc, OpLdADe: begin
        rf_d[RegA] = rd_data_i; cyc = 5'd8;
      end
      OpStHli, OpStHld: begin
        wr_x = '{en: 1'b1, addr: hl, data: rf_q[RegA]};
        rf_d[RegH] = hl_adj[15:8]; rf_d[RegL] = hl_adj[7:0];
        cyc = 5'd8;
      end
      OpLdAHli, OpLdAHld: begin
        rf_d[RegA] = rd_data_i;
        rf_d[RegH] = hl_adj[15:8]; rf_d[RegL] = hl_adj[7:0];
        cyc = 5'd8;
      end
      OpStSp: begin
        wr_x = '{en: 1'b1, addr: a16, data: sp_q[7:0]}; len = 2'd3; cyc = 5'd20;
      end
      OpJr, OpJrNz, OpJrZ, OpJrNc, OpJrC: begin
        len = 2'd2;
        case (op)
          OpJrNz:  take = ~flag_q[FlagZ];
          OpJrZ:   take = flag_q[FlagZ];
          OpJrNc:  take = ~flag_q[FlagC];
          OpJrC:   take = flag_q[FlagC];
          default: take = 1'b1;
        endcase
        jump = take;
        cyc  = take ? 5'd12 : 5'd8;
      end
      OpJp: begin
        jump = 1'b1; len = 2'd3; cyc = 5'd16;
      end
      OpLdhSt: begin
        addr_x = HighPage + {8'h00, lo};
        wr_x   = '{en: 1'b1, addr: addr_x, data: rf_q[RegA]};
        len    = 2'd2; cyc = 5'd12;
      end
      OpLdhLd: begin
        rf_d[RegA] = rd_data_i; len = 2'd2; cyc = 5'd12;
      end
      OpStHc: begin
        addr_x = HighPage + {8'h00, rf_q[RegC]};
        wr_x   = '{en: 1'b1, addr: addr_x, data: rf_q[RegA]};
        cyc    = 5'd8;
      end
      OpLdHc: begin
        rf_d[RegA] = rd_data_i; cyc = 5'd8;
      end
      OpStA16: begin
        wr_x = '{en: 1'b1, addr: a16, data: rf_q[RegA]}; len = 2'd3; cyc = 5'd16;
      end
      OpLdA16: begin
        rf_d[RegA] = rd_data_i; len = 2'd3; cyc = 5'd16;
      end
      OpLdHlSp: begin
        addr_x     = sp_q + off;
        rf_d[RegH] = addr_x[15:8]; rf_d[RegL] = addr_x[7:0];
        flag_d        = 4'b0000;
        flag_d[FlagH] = h_sum[4];
        flag_d[FlagC] = c_sum[8];
        len = 2'd2; cyc = 5'd12;
      end
      OpLdSpHl: begin
        sp_d = hl; cyc = 5'd8;
      end
      OpCpImm: begin
        flag_d = cmp_flags(rf_q[RegA], lo); len = 2'd2; cyc = 5'd8;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = (op == OpJp) ? a16 : target;
    end else begin
      pc_d = pc_q + {14'd0, len};
    end
  end

  always_comb begin
    res.next_pc       = pc_d;
    res.acc_value     = rf_d[RegA];
    res.hl_value      = {rf_d[RegH], rf_d[RegL]};
    res.flag_bits     = flag_d;
    res.cycle_count   = bad ? 5'd0 : cyc;
    res.mem_written   = wr_x.en;
    res.mem_address   = wr_x.en ? wr_x.addr : 16'h0000;
    res.mem_data      = wr_x.en ? wr_x.data : 8'h00;
    res.unimplemented = bad;
  end

  // pending high byte of LD (a16),SP owns the port for one cycle
  always_comb begin
    if (hi_pend_q) begin
      wr_o = '{en: 1'b1, addr: hi_addr_q, data: hi_data_q};
    end else begin
      wr_o    = wr_x;
      wr_o.en = wr_x.en & exec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) rf_q[i] <= 8'h00;
      flag_q    <= '0;
      sp_q      <= '0;
      pc_q      <= '0;
      a_vld_q   <= 1'b0;
      hi_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      hi_pend_q <= exec & (op == OpStSp);
      if (in_acc) begin
        a_vld_q <= 1'b1;
      end else if (exec) begin
        a_vld_q <= 1'b0;
      end
      if (exec) begin
        for (int i = 0; i < 7; i++) rf_q[i] <= rf_d[i];
        flag_q    <= flag_d;
        sp_q      <= sp_d;
        pc_q      <= pc_d;
        out_vld_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) a_q <= in_data_i;
    if (exec) begin
      out_q     <= res;
      hi_addr_q <= a16 + 16'd1;
      hi_data_q <= sp_q[15:8];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/sm83_load_jump_compare_unit_top.sv
// SM83 load/jump/compare unit: one instruction word in, one result word out.
// Each word issues its data memory read on the accept edge, then executes and
// writes back registers and memory once the output register is free.
// LD (a16),SP writes its high byte afterwards, on the single write port. After
// reset the data memory is swept to zero, one byte a cycle, through MEM_DEPTH
// bytes; no word is taken meanwhile. The output register lets the next word in
// while a result waits. MEM_DEPTH must be a power of two; addresses wrap to it.
// Depends on sm83ljc_pkg, sm83ljc_mem and sm83ljc_core.
module sm83_load_jump_compare_unit_top import sm83ljc_pkg::*; #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int Aw = $clog2(MEM_DEPTH);

  logic        mem_busy, rd_en;
  logic [15:0] rd_addr;
  logic [7:0]  rd_data;
  mem_wr_t     wr;

  sm83ljc_mem #(
    .Depth (MEM_DEPTH),
    .Aw    (Aw)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr[Aw-1:0]),
    .rd_data_o (rd_data),
    .wr_i      (wr),
    .busy_o    (mem_busy)
  );

  sm83ljc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_busy_i  (mem_busy),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_o        (wr)
  );

endmodule

FILE: src/sm83ljc_checker.sv
// Port-level checks for the SM83 load/jump/compare unit, bound to the top level.
// Depends on sm83ljc_pkg.
module sm83ljc_props import sm83ljc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  // one word in execute: the cycle after an accept is always stalled
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while previous still executing");

  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.unimplemented) |->
      (out_data_o.cycle_count == 5'd0 && !out_data_o.mem_written))
    else $error("unimplemented opcode reported work");

  a_no_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.mem_written) |->
      (out_data_o.mem_address == 16'h0000 && out_data_o.mem_data == 8'h00))
    else $error("store fields set without a store");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result word changed");

endmodule

bind sm83_load_jump_compare_unit_top sm83ljc_props u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
